// File: rtl/core/mlft_pkg.sv
// shared constants, codes and controller/datapath interface types of the mac learning table
package mlft_pkg;

   // defaults for the top level parameters
   localparam int TABLE_ENTRIES_DEFAULT  = 256;
   localparam int DATAPATH_COUNT_DEFAULT = 16;
   localparam int PORT_BITS_DEFAULT      = 16;

   // fixed field widths
   localparam int DP_BITS       = 4;
   localparam int MAC_BITS      = 48;
   localparam int VID_BITS      = 12;
   localparam int SCOPE_BITS    = DP_BITS + 1 + VID_BITS;
   localparam int IN_PORT_BITS  = 16;
   localparam int BUF_BITS      = 32;
   localparam int TIMEOUT_BITS  = 16;
   localparam int ACTION_BITS   = 2;
   localparam int REQ_DATA_BITS = 168;
   localparam int RSP_DATA_BITS = 136;
   localparam int MCAST_BIT     = 40;

   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd15;

   typedef enum logic {
      OP_PACKET = 1'b0,
      OP_CLOSE  = 1'b1
   } op_type;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_DROP       = 2'd0,
      ACT_FLOOD      = 2'd1,
      ACT_FORWARD    = 2'd2,
      ACT_CLOSE_DONE = 2'd3
   } action_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture the request
      logic clear;   // write an empty entry at the sweep address
      logic scan;    // read the entry at the sweep address
      logic learn;   // write the source entry
      logic finish;  // load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip;       // request needs no table scan
      logic is_close;   // request is a datapath close
      logic addr_last;  // sweep address is the last entry
      logic out_free;   // response register can take a new response
   } sts_type;

endpackage

// File: rtl/core/mlft_ram.sv
// generic simple dual-port ram with registered read
module mlft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/mlft_ctrl.sv
// controller state machine of the mac learning table
module mlft_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  mlft_pkg::sts_type sts,
   output mlft_pkg::cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_LEARN  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.addr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.skip) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan = 1'b1;
               if (sts.addr_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // last read data is evaluated in this cycle
            if (sts.is_close) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_LEARN;
            end
         end
         ST_LEARN: begin
            cmd.learn = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/mlft_dp.sv
// datapath of the mac learning table: request and result registers, table ram and scan logic
module mlft_dp #(
   parameter int TABLE_ENTRIES  = mlft_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int DATAPATH_COUNT = mlft_pkg::DATAPATH_COUNT_DEFAULT,
   parameter int PORT_BITS      = mlft_pkg::PORT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mlft_pkg::cmd_type                  cmd,
   output mlft_pkg::sts_type                  sts,
   input  logic                               req_tuser,
   input  logic [mlft_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               csr_valid,
   input  logic [mlft_pkg::TIMEOUT_BITS-1:0]  csr_data,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [mlft_pkg::ACTION_BITS-1:0]   rsp_tuser,
   output logic [mlft_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int ADDR_BITS        = $clog2(TABLE_ENTRIES);
   localparam int SCOPE_BITS       = mlft_pkg::SCOPE_BITS;
   localparam int MAC_BITS         = mlft_pkg::MAC_BITS;
   localparam int EGRESS_PORT_BITS = mlft_pkg::IN_PORT_BITS;
   localparam int ENTRY_BITS       = 1 + MAC_BITS + SCOPE_BITS + PORT_BITS;
   localparam logic [ADDR_BITS-1:0] ADDR_LAST = ADDR_BITS'(TABLE_ENTRIES - 1);
   localparam logic [8:0]           DP_LIMIT  = 9'(DATAPATH_COUNT);

   // captured request
   logic                                op_ff;
   logic [mlft_pkg::DP_BITS-1:0]        dp_ff;
   logic [MAC_BITS-1:0]                 src_ff;
   logic [MAC_BITS-1:0]                 dst_ff;
   logic [SCOPE_BITS-1:0]               scope_ff;
   logic [mlft_pkg::IN_PORT_BITS-1:0]   port_ff;
   logic [mlft_pkg::BUF_BITS-1:0]       buf_ff;
   logic [mlft_pkg::TIMEOUT_BITS-1:0]   timeout_ff;

   // sweep and scan bookkeeping
   logic [ADDR_BITS-1:0]        addr_ff;
   logic [ADDR_BITS-1:0]        addr_in;
   logic                        rd_vld_ff;
   logic [ADDR_BITS-1:0]        rd_idx_ff;
   logic                        dst_hit_ff;
   logic [EGRESS_PORT_BITS-1:0] dst_port_ff;
   logic                        src_hit_ff;
   logic [ADDR_BITS-1:0]        src_idx_ff;
   logic                        free_hit_ff;
   logic [ADDR_BITS-1:0]        free_idx_ff;

   logic                                rsp_valid_ff;
   logic [mlft_pkg::ACTION_BITS-1:0]    rsp_user_ff;
   logic [mlft_pkg::RSP_DATA_BITS-1:0]  rsp_data_ff;

   logic                    wr_en;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [ENTRY_BITS-1:0]   wr_data;
   logic [ENTRY_BITS-1:0]   rd_data;

   logic                    e_valid;
   logic [MAC_BITS-1:0]     e_mac;
   logic [SCOPE_BITS-1:0]   e_scope;
   logic [PORT_BITS-1:0]    e_port;
   logic                    is_close;
   logic                    dp_ok;
   logic                    skip;
   logic                    dst_mcast;
   logic                    close_match;
   logic                    pkt_eval;
   logic                    learn_fail;
   logic [mlft_pkg::ACTION_BITS-1:0] action;

   // request fields
   logic                              rq_tagged;
   logic [mlft_pkg::VID_BITS-1:0]     rq_vid;
   logic [mlft_pkg::DP_BITS-1:0]      rq_dp;

   assign rq_dp     = req_tdata[3:0];
   assign rq_tagged = req_tdata[100];
   assign rq_vid    = req_tdata[112:101];

   assign is_close  = (op_ff == mlft_pkg::OP_CLOSE);
   assign dp_ok     = (9'(dp_ff) < DP_LIMIT);
   assign skip      = !dp_ok || (!is_close && src_ff[mlft_pkg::MCAST_BIT]);
   assign dst_mcast = dst_ff[mlft_pkg::MCAST_BIT];

   assign e_valid = rd_data[ENTRY_BITS-1];
   assign e_mac   = rd_data[PORT_BITS+SCOPE_BITS +: MAC_BITS];
   assign e_scope = rd_data[PORT_BITS +: SCOPE_BITS];
   assign e_port  = rd_data[PORT_BITS-1:0];

   assign close_match = rd_vld_ff && is_close && e_valid
                        && (e_scope[SCOPE_BITS-1 -: mlft_pkg::DP_BITS] == dp_ff);
   assign pkt_eval    = rd_vld_ff && !is_close;

   assign sts.skip      = skip;
   assign sts.is_close  = is_close;
   assign sts.addr_last = (addr_ff == ADDR_LAST);
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign addr_in = (addr_ff == ADDR_LAST) ? '0 : addr_ff + 1'b1;

   // write port: clearing sweep, close write-back or learning
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (close_match) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff;
         wr_data = {1'b0, rd_data[ENTRY_BITS-2:0]};
      end else if (cmd.learn && (src_hit_ff || free_hit_ff)) begin
         wr_en   = 1'b1;
         wr_addr = src_hit_ff ? src_idx_ff : free_idx_ff;
         wr_data = {1'b1, src_ff, scope_ff, PORT_BITS'(port_ff)};
      end
   end

   mlft_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.scan),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         timeout_ff <= mlft_pkg::TIMEOUT_RESET;
      end else begin
         rd_vld_ff <= cmd.scan;
         if (cmd.load) begin
            addr_ff <= '0;
         end else if (cmd.clear || cmd.scan) begin
            addr_ff <= addr_in;
         end
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
      if (cmd.load) begin
         op_ff       <= req_tuser;
         dp_ff       <= rq_dp;
         src_ff      <= req_tdata[51:4];
         dst_ff      <= req_tdata[99:52];
         scope_ff    <= {rq_dp, rq_tagged, rq_tagged ? rq_vid : {mlft_pkg::VID_BITS{1'b0}}};
         port_ff     <= req_tdata[128:113];
         buf_ff      <= req_tdata[160:129];
         dst_hit_ff  <= 1'b0;
         src_hit_ff  <= 1'b0;
         free_hit_ff <= 1'b0;
      end else if (pkt_eval) begin
         if (!dst_hit_ff && !dst_mcast && e_valid && e_scope == scope_ff
             && e_mac == dst_ff) begin
            dst_hit_ff  <= 1'b1;
            dst_port_ff <= EGRESS_PORT_BITS'(e_port);
         end
         if (!src_hit_ff && e_valid && e_scope == scope_ff && e_mac == src_ff) begin
            src_hit_ff <= 1'b1;
            src_idx_ff <= rd_idx_ff;
         end
         if (!free_hit_ff && !e_valid) begin
            free_hit_ff <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
      end
   end

   // result assembly
   assign learn_fail = !is_close && !skip && !src_hit_ff && !free_hit_ff;

   always_comb begin
      if (is_close) begin
         action = mlft_pkg::ACT_CLOSE_DONE;
      end else if (skip) begin
         action = mlft_pkg::ACT_DROP;
      end else if (dst_hit_ff) begin
         action = mlft_pkg::ACT_FORWARD;
      end else begin
         action = mlft_pkg::ACT_FLOOD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_user_ff <= action;
         if (is_close) begin
            rsp_data_ff <= '0;
         end else if (action == mlft_pkg::ACT_FORWARD) begin
            rsp_data_ff <= {7'b0, learn_fail, timeout_ff, dst_ff, buf_ff, port_ff,
                            dst_port_ff};
         end else begin
            rsp_data_ff <= {7'b0, learn_fail, {mlft_pkg::TIMEOUT_BITS{1'b0}}, dst_ff,
                            buf_ff, port_ff, {EGRESS_PORT_BITS{1'b0}}};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/core/mac_learning_forwarding_table_top.sv
// top level of the mac learning forwarding table
// packet: whole table scan, one ram read a cycle, then source learning and response load;
//   close: whole table scan and response load; drop or out-of-range: response load only
// requests: one at a time, the next taken in the cycle after the response is loaded
// reset: synchronous; idle timeout returns to 15, then a sweep writes an empty entry to every
//   table address with req_tready low throughout
module mac_learning_forwarding_table_top #(
   parameter int TABLE_ENTRIES  = mlft_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int DATAPATH_COUNT = mlft_pkg::DATAPATH_COUNT_DEFAULT,
   parameter int PORT_BITS      = mlft_pkg::PORT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tuser,   // operation
   // datapath_id, src_mac, dst_mac, vlan_tagged, vlan_id, in_port, buffer_id, zero pad
   input  logic [mlft_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mlft_pkg::ACTION_BITS-1:0]   rsp_tuser,   // action
   // egress port, in_port_echo, buffer_id_echo, dst_mac_echo, rule_timeout, learn_failed, pad
   output logic [mlft_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // idle timeout register write
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mlft_pkg::TIMEOUT_BITS-1:0]  csr_data
);

   mlft_pkg::cmd_type cmd;
   mlft_pkg::sts_type sts;

   // register write always taken, block is idle by contract
   assign csr_ready = 1'b1;

   // sequencing: clearing sweep, request capture, table scan, learn, response
   mlft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // table ram, compare logic and response register
   mlft_dp #(
      .TABLE_ENTRIES  (TABLE_ENTRIES),
      .DATAPATH_COUNT (DATAPATH_COUNT),
      .PORT_BITS      (PORT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
